FILE: design/bpf_pkg.sv
// Package of the path flattener: coordinate, opcode, result-kind and job types,
// the back-end state encoding and shared constants. No dependencies.
`default_nettype none
package bpf_pkg;

  localparam int unsigned MAX_SEGMENTS = 63;
  localparam int unsigned CW           = 20;

  localparam logic [15:0] FLAT_RESET = 16'd64;
  localparam logic        CFG_IDX_FLATNESS = 1'b0;
  localparam logic [1:0]  SP_TWO     = 2'd2;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    OP_MOVE  = 3'd0,
    OP_LINE  = 3'd1,
    OP_QUAD  = 3'd2,
    OP_CUBIC = 3'd3,
    OP_CLOSE = 3'd4,
    OP_CLEAR = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,
    KIND_NEXT  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACT_LINE,
    ACT_QUAD,
    ACT_CUBIC,
    ACT_CLOSE
  } act_e;

  // One unit of back-end work. For a line only px/py[0] (open point) and [3]
  // (end) matter; for a quadratic [0..2]; for a close [0] holds the start.
  typedef struct packed {
    logic             open;
    act_e             act;
    coord_t [3:0]     px;
    coord_t [3:0]     py;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } qwr_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_OPEN, BK_LINE, BK_CLOSE,
    BK_DIFF, BK_SQA, BK_SQB, BK_NEED,
    BK_NSQ, BK_N4, BK_PROD, BK_CMP,
    BK_DEN2, BK_DEN3,
    BK_AB, BK_W, BK_ACC, BK_NUM, BK_DIV, BK_EMIT
  } back_state_e;

endpackage
`default_nettype wire

FILE: design/bpf_front.sv
// Command decoder of the path flattener: keeps the current point, subpath start
// and subpath flags, and turns drawing commands into jobs. Uses bpf_pkg.
`default_nettype none
module bpf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [2:0]     opcode_i,
  input  wire bpf_pkg::coord_t c1x_i,
  input  wire bpf_pkg::coord_t c1y_i,
  input  wire bpf_pkg::coord_t c2x_i,
  input  wire bpf_pkg::coord_t c2y_i,
  input  wire bpf_pkg::coord_t ex_i,
  input  wire bpf_pkg::coord_t ey_i,
  output bpf_pkg::qwr_t       wr_o
);
  import bpf_pkg::*;

  coord_t     cur_x_q, cur_y_q, st_x_q, st_y_q;
  coord_t     cur_x_d, cur_y_d, st_x_d, st_y_d;
  logic       pending_q, pending_d, started_q, started_d;
  logic [1:0] sp_q, sp_d;
  logic       open_c;

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    st_x_d    = st_x_q;
    st_y_d    = st_y_q;
    pending_d = pending_q;
    started_d = started_q;
    sp_d      = sp_q;
    wr_o      = '0;
    open_c    = pending_q | ~started_q;
    if (accept_i) begin
      case (opcode_i)
        OP_MOVE: begin
          cur_x_d = ex_i; cur_y_d = ey_i; st_x_d = ex_i; st_y_d = ey_i;
          pending_d = 1'b1;
        end
        OP_LINE, OP_QUAD, OP_CUBIC: begin
          if (opcode_i == OP_LINE && !started_q && !pending_q) begin
            // A line on a fresh path behaves as a move.
            cur_x_d = ex_i; cur_y_d = ey_i; st_x_d = ex_i; st_y_d = ey_i;
            pending_d = 1'b1;
          end else begin
            wr_o.push       = 1'b1;
            wr_o.job.open   = open_c;
            wr_o.job.act    = (opcode_i == OP_LINE) ? ACT_LINE :
                              (opcode_i == OP_QUAD) ? ACT_QUAD : ACT_CUBIC;
            wr_o.job.px[0]  = cur_x_q;
            wr_o.job.py[0]  = cur_y_q;
            wr_o.job.px[1]  = c1x_i;
            wr_o.job.py[1]  = c1y_i;
            wr_o.job.px[2]  = (opcode_i == OP_CUBIC) ? c2x_i : ex_i;
            wr_o.job.py[2]  = (opcode_i == OP_CUBIC) ? c2y_i : ey_i;
            wr_o.job.px[3]  = ex_i;
            wr_o.job.py[3]  = ey_i;
            // Every drawing command adds at least one point after the open
            // point, so the saturating count always ends at two.
            started_d = 1'b1;
            pending_d = 1'b0;
            sp_d      = SP_TWO;
            cur_x_d   = ex_i;
            cur_y_d   = ey_i;
          end
        end
        OP_CLOSE: begin
          if (!pending_q && started_q && sp_q == SP_TWO) begin
            wr_o.push      = 1'b1;
            wr_o.job.act   = ACT_CLOSE;
            wr_o.job.px[0] = st_x_q;
            wr_o.job.py[0] = st_y_q;
          end
          cur_x_d = st_x_q; cur_y_d = st_y_q;
          pending_d = 1'b1;
        end
        OP_CLEAR: begin
          cur_x_d = '0; cur_y_d = '0; st_x_d = '0; st_y_d = '0;
          pending_d = 1'b0; started_d = 1'b0; sp_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; st_x_q <= '0; st_y_q <= '0;
      pending_q <= 1'b0; started_q <= 1'b0; sp_q <= '0;
    end else begin
      cur_x_q <= cur_x_d; cur_y_q <= cur_y_d; st_x_q <= st_x_d; st_y_q <= st_y_d;
      pending_q <= pending_d; started_q <= started_d; sp_q <= sp_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/bpf_queue.sv
// Two-entry job queue between the decoder and the evaluator of the path
// flattener. Uses bpf_pkg for the job type.
`default_nettype none
module bpf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bpf_pkg::qwr_t wr_i,
  input  wire logic          pop_i,
  output bpf_pkg::job_t      head_o,
  output logic               empty_o,
  output logic               full_o
);
  import bpf_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wp_q] <= wr_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i.push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i.push} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i.push || pop_i) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("job queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job queue count out of range");
`endif

endmodule
`default_nettype wire

FILE: design/bpf_div.sv
// Restoring divider of the path flattener: rounds a signed numerator by a
// positive divisor with floor semantics, one quotient bit per cycle. Uses bpf_pkg.
`default_nettype none
module bpf_div #(
  parameter int unsigned NW = 41,
  parameter int unsigned DW = 19
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic [DW-1:0]        dvs_i,
  output logic                      busy_o,
  output bpf_pkg::coord_t           quo_o
);
  import bpf_pkg::*;

  localparam int unsigned QB = CW + 1;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned CNTW = $clog2(QB + 1);

  logic            neg_q;
  logic [RW-1:0]   rem_q;
  logic [QB-1:0]   quo_q;
  logic [DW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   absn;
  logic [NW:0]     mag;
  logic [RW-1:0]   trial;
  logic [QB-1:0]   signed_quo;

  // Floor of a negative quotient: ceil of the magnitude, then negate.
  assign absn  = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign mag   = {1'b0, absn} + (num_i[NW-1] ? ((NW+1)'(dvs_i) - 1'b1) : '0);
  assign trial = {rem_q[RW-2:0], quo_q[QB-1]};
  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quo_o  = signed_quo[CW-1:0];
  assign busy_o = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      rem_q <= RW'(mag >> QB);
      quo_q <= mag[QB-1:0];
      dvs_q <= dvs_i;
    end else if (busy_o) begin
      if (trial >= RW'(dvs_q)) begin
        rem_q <= trial - RW'(dvs_q);
        quo_q <= {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(QB);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/bpf_back.sv
// Evaluator of the path flattener: finds the segment count of a curve, evaluates
// Bernstein points and drives the output register. Uses bpf_pkg and bpf_div.
`default_nettype none
module bpf_back #(
  parameter int unsigned MaxSegments = bpf_pkg::MAX_SEGMENTS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bpf_pkg::job_t job_i,
  input  wire logic          valid_i,
  output logic               pop_o,
  input  wire logic [15:0]   flat_i,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [39:0]        m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast
);
  import bpf_pkg::*;

  localparam int unsigned SegW = $clog2(MaxSegments + 1);
  localparam int unsigned DenW = 3 * SegW;
  localparam int unsigned DW   = DenW + 1;
  localparam int unsigned WW   = 3 * SegW + 1;
  localparam int unsigned AW   = 3 * SegW + CW + 2;
  localparam int unsigned NW   = AW + 1;
  localparam int unsigned DfW  = CW + 3;
  localparam int unsigned SqW  = 2 * DfW;
  localparam int unsigned DsW  = SqW + 1;
  localparam int unsigned NdW  = DsW + 8;
  localparam int unsigned PW   = 4 * SegW + 32;

  back_state_e state_q, state_d;

  logic signed [DfW-1:0] dxa_q, dya_q, dxb_q, dyb_q;
  logic [SqW-1:0]        sqx_q, sqy_q;
  logic [DsW-1:0]        d0_q, dsum, dmax;
  logic [NdW-1:0]        need_q;
  logic [31:0]           f2_q;
  logic [15:0]           f_eff;
  logic [SegW-1:0]       n_q, i_q, a_c;
  logic [2*SegW-1:0]     n2_q;
  logic [4*SegW-1:0]     n4_q;
  logic [PW-1:0]         prod_q;
  logic [DenW-1:0]       den_q;
  logic [WW-1:0]         a_w, b_w, a2_q, b2_q, ab_q;
  logic [WW-1:0]         w_q [4];
  logic [1:0]            j_q;
  logic signed [AW-1:0]  accx_q, accy_q;
  logic signed [WW:0]    wsg;
  logic signed [WW+CW:0] tx, ty;
  logic signed [NW-1:0]  numx, numy;
  logic [1:0]            deg;
  logic                  cubic;
  logic                  out_free, load;
  coord_t                ld_x, ld_y;
  kind_e                 ld_kind;
  logic                  ld_last;
  logic                  div_start, busy_x, busy_y;
  coord_t                qx, qy;
  coord_t                ox_q, oy_q;
  kind_e                 okind_q;
  logic                  olast_q, ovalid_q;

  assign cubic    = (job_i.act == ACT_CUBIC);
  assign deg      = cubic ? 2'd3 : 2'd2;
  assign f_eff    = (flat_i == '0) ? FLAT_RESET : flat_i;
  assign out_free = !ovalid_q || m_tready;
  assign a_c      = n_q - i_q;
  assign a_w      = WW'(a_c);
  assign b_w      = WW'(i_q);
  assign dsum     = DsW'(sqx_q) + DsW'(sqy_q);
  assign dmax     = (cubic && dsum > d0_q) ? dsum : d0_q;
  assign wsg      = $signed({1'b0, w_q[j_q]});
  assign tx       = wsg * job_i.px[j_q];
  assign ty       = wsg * job_i.py[j_q];
  assign numx     = $signed({accx_q, 1'b0}) + $signed(NW'(den_q));
  assign numy     = $signed({accy_q, 1'b0}) + $signed(NW'(den_q));

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    ld_x      = job_i.px[0];
    ld_y      = job_i.py[0];
    ld_kind   = KIND_FIRST;
    ld_last   = 1'b0;
    div_start = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          if (job_i.open) state_d = BK_OPEN;
          else if (job_i.act == ACT_LINE) state_d = BK_LINE;
          else if (job_i.act == ACT_CLOSE) state_d = BK_CLOSE;
          else state_d = BK_DIFF;
        end
      end
      BK_OPEN: begin
        if (out_free) begin
          load = 1'b1;
          state_d = (job_i.act == ACT_LINE) ? BK_LINE : BK_DIFF;
        end
      end
      BK_LINE: begin
        if (out_free) begin
          load = 1'b1; ld_x = job_i.px[3]; ld_y = job_i.py[3];
          ld_kind = KIND_NEXT; ld_last = 1'b1; pop_o = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_CLOSE: begin
        if (out_free) begin
          load = 1'b1; ld_kind = KIND_CLOSE; ld_last = 1'b1; pop_o = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_DIFF: state_d = BK_SQA;
      BK_SQA:  state_d = BK_SQB;
      BK_SQB:  state_d = BK_NEED;
      BK_NEED: state_d = BK_NSQ;
      BK_NSQ:  state_d = (n_q == SegW'(MaxSegments)) ? BK_DEN2 : BK_N4;
      BK_N4:   state_d = BK_PROD;
      BK_PROD: state_d = BK_CMP;
      BK_CMP:  state_d = (prod_q >= PW'(need_q)) ? BK_DEN2 : BK_NSQ;
      BK_DEN2: state_d = BK_DEN3;
      BK_DEN3: state_d = BK_AB;
      BK_AB:   state_d = BK_W;
      BK_W:    state_d = BK_ACC;
      BK_ACC:  if (j_q == deg) state_d = BK_NUM;
      BK_NUM: begin
        div_start = 1'b1;
        state_d = BK_DIV;
      end
      BK_DIV:  if (!busy_x && !busy_y) state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          load = 1'b1; ld_x = qx; ld_y = qy; ld_kind = KIND_NEXT;
          ld_last = (i_q == n_q);
          if (i_q == n_q) begin
            pop_o = 1'b1;
            state_d = BK_IDLE;
          end else begin
            state_d = BK_AB;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_DIFF: begin
        dxa_q <= DfW'(job_i.px[0]) - (DfW'(job_i.px[1]) <<< 1) + DfW'(job_i.px[2]);
        dya_q <= DfW'(job_i.py[0]) - (DfW'(job_i.py[1]) <<< 1) + DfW'(job_i.py[2]);
        dxb_q <= DfW'(job_i.px[1]) - (DfW'(job_i.px[2]) <<< 1) + DfW'(job_i.px[3]);
        dyb_q <= DfW'(job_i.py[1]) - (DfW'(job_i.py[2]) <<< 1) + DfW'(job_i.py[3]);
        f2_q  <= f_eff * f_eff;
      end
      BK_SQA: begin
        sqx_q <= SqW'(dxa_q * dxa_q);
        sqy_q <= SqW'(dya_q * dya_q);
      end
      BK_SQB: begin
        d0_q  <= dsum;
        sqx_q <= SqW'(dxb_q * dxb_q);
        sqy_q <= SqW'(dyb_q * dyb_q);
      end
      BK_NEED: begin
        // K*D with K = 16 for a quadratic and 144 for a cubic.
        need_q <= cubic ? ((NdW'(dmax) << 7) + (NdW'(dmax) << 4)) : (NdW'(dmax) << 4);
      end
      BK_NSQ:  n2_q   <= n_q * n_q;
      BK_N4:   n4_q   <= n2_q * n2_q;
      BK_PROD: prod_q <= PW'(n4_q) * PW'(f2_q);
      BK_DEN2: n2_q   <= n_q * n_q;
      BK_DEN3: den_q  <= cubic ? DenW'(n2_q * n_q) : DenW'(n2_q);
      BK_AB: begin
        a2_q <= a_w * a_w;
        b2_q <= b_w * b_w;
        ab_q <= a_w * b_w;
      end
      BK_W: begin
        if (cubic) begin
          w_q[0] <= a2_q * a_w;
          w_q[1] <= WW'(3) * a2_q * b_w;
          w_q[2] <= WW'(3) * b2_q * a_w;
          w_q[3] <= b2_q * b_w;
        end else begin
          w_q[0] <= a2_q;
          w_q[1] <= ab_q << 1;
          w_q[2] <= b2_q;
          w_q[3] <= '0;
        end
        accx_q <= '0;
        accy_q <= '0;
      end
      BK_ACC: begin
        accx_q <= accx_q + AW'(tx);
        accy_q <= accy_q + AW'(ty);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      n_q <= '0; i_q <= '0; j_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_NEED) n_q <= SegW'(1);
      else if (state_q == BK_CMP && state_d == BK_NSQ) n_q <= n_q + 1'b1;
      if (state_q == BK_DEN3) i_q <= SegW'(1);
      else if (state_q == BK_EMIT && load) i_q <= i_q + 1'b1;
      if (state_q == BK_W) j_q <= '0;
      else if (state_q == BK_ACC) j_q <= j_q + 1'b1;
    end
  end

  bpf_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(numx),
    .dvs_i({den_q, 1'b0}), .busy_o(busy_x), .quo_o(qx)
  );
  bpf_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(numy),
    .dvs_i({den_q, 1'b0}), .busy_o(busy_y), .quo_o(qy)
  );

  always_ff @(posedge clk_i) begin
    if (load) begin
      ox_q <= ld_x; oy_q <= ld_y; okind_q <= ld_kind; olast_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (load) ovalid_q <= 1'b1;
    else if (m_tready) ovalid_q <= 1'b0;
  end

  assign m_tvalid = ovalid_q;
  assign m_tdata  = {oy_q, ox_q};
  assign m_tuser  = okind_q;
  assign m_tlast  = olast_q;

`ifndef SYNTHESIS
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && okind_q == KIND_CLOSE |-> olast_q) else $error("close not last");
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && okind_q == KIND_FIRST |-> !olast_q) else $error("first point last");
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_NUM |=> busy_x && busy_y) else $error("divider did not start");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> load && ld_last) else $error("job retired without last point");
`endif

endmodule
`default_nettype wire

FILE: design/bezier_path_flattener.sv
// Top level of the path flattener: configuration register, command decoder,
// job queue and curve evaluator. Uses bpf_pkg, bpf_front, bpf_queue, bpf_back.
//
// Usage: path commands enter on the s_ stream (opcode in s_tuser, six Q16.4
// coordinates in s_tdata) and flattened points leave on the m_ stream (kind in
// m_tuser, x and y in m_tdata, m_tlast on the final point of a command).
// The decoder takes a command whenever the two-entry job queue has
// room; move, clear, a close without a marker and unused opcodes produce no job.
// A line point or a close marker leaves through the output register once its job
// reaches the evaluator, after a subpath opening point when one goes first. A curve
// first finds its difference bound, then tries segment counts from one upward (at
// most MAX_SEGMENTS), works out the denominator, and then for each point of a
// quadratic or cubic computes the weights, one multiply-accumulate per control
// point and a 21-step restoring division per coordinate.
// Reset clears the current point, subpath start and all subpath flags, empties
// the queue and loads flatness with 64 (0.25). A flatness of zero acts as 64.
// When the receiver stalls, the finished point waits in the output register;
// the evaluator stops, and the decoder keeps taking commands until the queue fills.
// The flatness register sits at address 0 of the APB port and should be written
// only while no command is in flight.
`default_nettype none
module bezier_path_flattener #(
  parameter int unsigned MaxSegments = bpf_pkg::MAX_SEGMENTS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // command stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [19:0] ctrl1_x, [39:20] ctrl1_y, [59:40] ctrl2_x, [79:60] ctrl2_y,
  // [99:80] end_x, [119:100] end_y
  input  wire logic [119:0] s_tdata,
  // [2:0] opcode
  input  wire logic [2:0]   s_tuser,
  // point stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [19:0] point_x, [39:20] point_y
  output logic [39:0]       m_tdata,
  // [1:0] kind
  output logic [1:0]        m_tuser,
  output logic              m_tlast,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bpf_pkg::*;

  logic [15:0] flat_q;
  logic        accept, full, empty, pop;
  qwr_t        wr;
  job_t        head;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == CFG_IDX_FLATNESS) ? {16'd0, flat_q} : 32'd0;
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_q <= FLAT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == CFG_IDX_FLATNESS) begin
      flat_q <= pwdata[15:0];
    end
  end

  bpf_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .opcode_i(s_tuser),
    .c1x_i(s_tdata[19:0]), .c1y_i(s_tdata[39:20]),
    .c2x_i(s_tdata[59:40]), .c2y_i(s_tdata[79:60]),
    .ex_i(s_tdata[99:80]), .ey_i(s_tdata[119:100]),
    .wr_o(wr)
  );

  bpf_queue u_queue (
    .clk_i, .rst_ni, .wr_i(wr), .pop_i(pop), .head_o(head),
    .empty_o(empty), .full_o(full)
  );

  bpf_back #(.MaxSegments(MaxSegments)) u_back (
    .clk_i, .rst_ni, .job_i(head), .valid_i(!empty), .pop_o(pop),
    .flat_i(flat_q), .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

endmodule
`default_nettype wire

FILE: tb/tb_bezier_path_flattener.sv
// Self-checking testbench of bezier_path_flattener: drives path commands and
// APB writes, predicts the flattened point stream. Uses bpf_pkg and the block.
`default_nettype none
module tb_bezier_path_flattener;
  import bpf_pkg::*;

  // Opcodes without a command behind them.
  localparam logic [2:0] OpUnusedLo = 3'd6;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  typedef struct packed {
    logic [19:0] x;
    logic [19:0] y;
    logic [1:0]  kind;
    logic        last;
  } point_t;

  // Scoreboard: holds a copy of the path state and a queue of expected points.
  class path_scoreboard;
    point_t      pend_q[$];
    logic [15:0] flat;
    longint      cur_x, cur_y, st_x, st_y;
    bit          pending, started;
    int          sp_cnt;
    int          errors;
    int          n_cmds, n_points;

    function void do_reset();
      flat = FLAT_RESET;
      cur_x = 0; cur_y = 0; st_x = 0; st_y = 0;
      pending = 0; started = 0; sp_cnt = 0;
    endfunction

    function void push_point(longint x, longint y, kind_e k);
      point_t p;
      p.x = x[19:0]; p.y = y[19:0]; p.kind = k; p.last = 1'b0;
      pend_q.insert(pend_q.size(), p);
    endfunction

    function void draw_point(longint x, longint y);
      push_point(x, y, KIND_NEXT);
      if (sp_cnt < 2) sp_cnt++;
      cur_x = x; cur_y = y;
    endfunction

    function void open_subpath();
      if (!pending && started) return;
      push_point(cur_x, cur_y, KIND_FIRST);
      sp_cnt = 1; started = 1; pending = 0;
    endfunction

    function longint sq_diff(longint ax, longint ay, longint bx, longint by,
                             longint cx, longint cy);
      longint dx, dy;
      dx = ax - 2 * bx + cx;
      dy = ay - 2 * by + cy;
      return dx * dx + dy * dy;
    endfunction

    function int segments(longint dsq, longint k);
      longint f, f2, need, nn;
      f = (flat == 0) ? 64 : flat;
      f2 = f * f;
      need = k * dsq;
      for (int n = 1; n < MAX_SEGMENTS; n++) begin
        nn = n * n;
        if (nn * nn * f2 >= need) return n;
      end
      return MAX_SEGMENTS;
    endfunction

    function longint rdiv(longint num, longint den);
      longint a, b, q;
      a = 2 * num + den;
      b = 2 * den;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function void flatten(int deg, longint px[4], longint py[4], longint dsq,
                          longint k);
      int n;
      longint a, b, den, sx, sy;
      longint w[4];
      n = segments(dsq, k);
      for (int i = 1; i <= n; i++) begin
        a = n - i; b = i;
        if (deg == 2) begin
          w[0] = a * a; w[1] = 2 * a * b; w[2] = b * b; w[3] = 0; den = n * n;
        end else begin
          w[0] = a * a * a; w[1] = 3 * a * a * b; w[2] = 3 * a * b * b;
          w[3] = b * b * b; den = n * n * n;
        end
        sx = 0; sy = 0;
        for (int j = 0; j <= deg; j++) begin
          sx += w[j] * px[j];
          sy += w[j] * py[j];
        end
        draw_point(rdiv(sx, den), rdiv(sy, den));
      end
    endfunction

    // Notes an accepted command and queues the points it must produce.
    function void note_command(logic [2:0] op, logic [119:0] d);
      longint c1x, c1y, c2x, c2y, ex, ey, d0, d1;
      longint px[4], py[4];
      int old_size;
      c1x = $signed(d[19:0]);   c1y = $signed(d[39:20]);
      c2x = $signed(d[59:40]);  c2y = $signed(d[79:60]);
      ex  = $signed(d[99:80]);  ey  = $signed(d[119:100]);
      old_size = pend_q.size();
      n_cmds++;
      case (op)
        OP_MOVE: begin
          cur_x = ex; st_x = ex; cur_y = ey; st_y = ey; pending = 1;
        end
        OP_LINE: begin
          if (!started && !pending) begin
            cur_x = ex; st_x = ex; cur_y = ey; st_y = ey; pending = 1;
          end else begin
            open_subpath();
            draw_point(ex, ey);
          end
        end
        OP_QUAD: begin
          open_subpath();
          px[0] = cur_x; py[0] = cur_y; px[1] = c1x; py[1] = c1y;
          px[2] = ex; py[2] = ey; px[3] = 0; py[3] = 0;
          flatten(2, px, py, sq_diff(px[0], py[0], px[1], py[1], px[2], py[2]), 16);
        end
        OP_CUBIC: begin
          open_subpath();
          px[0] = cur_x; py[0] = cur_y; px[1] = c1x; py[1] = c1y;
          px[2] = c2x; py[2] = c2y; px[3] = ex; py[3] = ey;
          d0 = sq_diff(px[0], py[0], px[1], py[1], px[2], py[2]);
          d1 = sq_diff(px[1], py[1], px[2], py[2], px[3], py[3]);
          flatten(3, px, py, (d0 > d1) ? d0 : d1, 144);
        end
        OP_CLOSE: begin
          if (!pending && started && sp_cnt >= 2) push_point(st_x, st_y, KIND_CLOSE);
          cur_x = st_x; cur_y = st_y; pending = 1;
        end
        OP_CLEAR: begin
          cur_x = 0; cur_y = 0; st_x = 0; st_y = 0;
          pending = 0; started = 0; sp_cnt = 0;
        end
        default: ;
      endcase
      if (pend_q.size() > old_size) pend_q[pend_q.size() - 1].last = 1'b1;
    endfunction

    // Checks one accepted point against the oldest expectation.
    function void check_point(point_t got);
      point_t want;
      n_points++;
      if (pend_q.size() == 0) begin
        $error("unexpected point x=%h y=%h kind=%0d", got.x, got.y, got.kind);
        errors++;
        return;
      end
      want = pend_q.pop_front();
      if (got.x !== want.x) begin
        $error("point_x expected %h actual %h", want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
        $error("point_y expected %h actual %h", want.y, got.y); errors++;
      end
      if (got.kind !== want.kind) begin
        $error("kind expected %0d actual %0d", want.kind, got.kind); errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [119:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bezier_path_flattener DUT (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  path_scoreboard sb;
  bit  quiet;              // no idling in the closing part of the run
  longint cycles;
  localparam longint CycleLimit = 2_000_000;
  localparam int SettleCycles = 400;

  // Sample the point stream at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      sb.check_point({m_tdata[19:0], m_tdata[39:20], m_tuser, m_tlast});
  end

  // Receiver: random stall bursts, moved at the falling edge.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--; m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 6) - 1; m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("bezier_path_flattener test failed");
        $finish;
      end
    end
  end

  // Sends one command; the transfer completes at a rising edge with tready high.
  // tvalid stays high afterwards until the next idle burst or drain.
  task automatic send_cmd(logic [2:0] op, logic [119:0] d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_command(op, d);
    @(negedge clk_i);
  endtask

  task automatic send_pts(logic [2:0] op, logic [19:0] c1x, logic [19:0] c1y,
                          logic [19:0] c2x, logic [19:0] c2y,
                          logic [19:0] ex, logic [19:0] ey);
    send_cmd(op, {ey, ex, c2y, c2x, c1y, c1x});
  endtask

  // Stops sending, waits until all expected points arrived, then lets the
  // block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pend_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write: setup cycle then access cycle.
  task automatic write_flatness(logic [15:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {CFG_IDX_FLATNESS, 2'b00}; pwdata <= {16'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.flat = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Random coordinate: mostly small values near the origin, sometimes extreme.
  function automatic logic [19:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2, 3: return 20'($urandom());
      default: return 20'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [2:0] rnd_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return OP_MOVE;
    if (r < 40) return OP_LINE;
    if (r < 60) return OP_QUAD;
    if (r < 80) return OP_CUBIC;
    if (r < 92) return OP_CLOSE;
    if (r < 96) return OP_CLEAR;
    return 3'($urandom_range(OpUnusedLo, OpUnusedHi));
  endfunction

  task automatic random_cmds(int count);
    logic [119:0] d;
    for (int i = 0; i < count; i++) begin
      d = 120'({$urandom(), $urandom(), $urandom(), $urandom()});
      if ($urandom_range(0, 3) != 0)
        d = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_coord()};
      send_cmd(rnd_op(), d);
    end
  endtask

  initial begin
    sb = new();
    sb.do_reset();
    quiet = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset flatness. A line on a fresh path acts as a
    // move; a close on a single point gives no marker.
    send_pts(OP_LINE, 0, 0, 0, 0, 20'd100, 20'd50);
    send_pts(OP_LINE, 0, 0, 0, 0, 20'd200, 20'd50);
    send_pts(OP_CLOSE, 0, 0, 0, 0, 0, 0);
    send_pts(OP_LINE, 0, 0, 0, 0, 20'd200, 20'd300);
    send_pts(OP_CLOSE, 0, 0, 0, 0, 0, 0);
    send_pts(OP_CLOSE, 0, 0, 0, 0, 0, 0);
    send_pts(OP_QUAD, 20'd160, 20'd400, 0, 0, 20'd300, 20'd0);
    send_pts(OP_CUBIC, 20'hFFF00, 20'd80, 20'd60, 20'hFFFC0, 20'd7, 20'd9);
    send_pts(OP_QUAD, 20'd7, 20'd9, 0, 0, 20'd7, 20'd9);
    send_pts(OP_MOVE, 0, 0, 0, 0, 20'h80000, 20'h7FFFF);
    send_pts(OP_CUBIC, 20'h7FFFF, 20'h80000, 20'h80000, 20'h7FFFF,
             20'h7FFFF, 20'h80000);
    send_pts(OP_CLOSE, 0, 0, 0, 0, 0, 0);
    send_cmd(OpUnusedLo, {120{1'b1}});
    send_cmd(OpUnusedHi, '0);
    send_pts(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_pts(OP_QUAD, 20'h7FFFF, 20'h7FFFF, 0, 0, 20'h80000, 20'h80000);
    send_pts(OP_LINE, 0, 0, 0, 0, 20'hFFFFF, 20'd1);
    // Sender holds off until the block has delivered everything.
    drain();

    write_flatness(16'd0);
    send_pts(OP_MOVE, 0, 0, 0, 0, 0, 0);
    send_pts(OP_QUAD, 20'd400, 20'd400, 0, 0, 20'd800, 20'd0);
    drain();
    write_flatness(16'hFFFF);
    send_pts(OP_CUBIC, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000, 0, 0);
    send_pts(OP_QUAD, 20'd1000, 20'd5000, 0, 0, 20'd1, 20'd2);
    drain();

    write_flatness(16'd1);
    random_cmds(25);
    drain();
    write_flatness(16'($urandom_range(1, 65535)));
    random_cmds(25);
    drain();
    write_flatness(16'($urandom_range(16, 1024)));
    random_cmds(20);
    drain();
    write_flatness(FLAT_RESET);
    quiet = 1;
    random_cmds(20);
    drain();

    $display("Ran %0d commands and checked %0d points over flatness 0, 1, 64,",
             sb.n_cmds, sb.n_points);
    $display("65535 and random values, with idle bursts on both streams.");
    if (sb.errors == 0 && sb.pend_q.size() == 0) begin
      $display("bezier_path_flattener test passed");
    end else begin
      $display("bezier_path_flattener test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
